[rtl/assert_macros.svh]
// Assertion macros used by the allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define TIA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/tia_pkg.sv]
// Types and constants of the transaction identity allocator.
`default_nettype none

package tia_pkg;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 8;
  localparam int CHUNK_W  = 32;
  localparam int OFF_W    = 5;
  localparam int FIRST_ID = 1;

  localparam logic [CMD_W-1:0] CMD_ASSIGN     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_STATUS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET_STATUS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;

  localparam logic RC_OK  = 1'b0;
  localparam logic RC_ERR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOOKUP,
    ST_FINISH
  } tia_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic lookup;
    logic commit;
  } tia_dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_search;
    logic in_lookup;
    logic hit;
    logic last_step;
    logic out_free;
  } tia_dp_sts_t;

endpackage

`default_nettype wire

[rtl/tia_in_if.sv]
// Command channel of the allocator: valid, ready and the command payload.
`default_nettype none

interface tia_in_if import tia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [ID_W-1:0]  ident;
  logic             new_status;

  modport source (output valid, cmd, ident, new_status, input ready);
  modport sink   (input valid, cmd, ident, new_status, output ready);
endinterface

`default_nettype wire

[rtl/tia_out_if.sv]
// Result channel of the allocator: valid, ready and the result payload.
`default_nettype none

interface tia_out_if import tia_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            result_code;
  logic [ID_W-1:0] ident_out;
  logic            status_out;
  logic            not_in_use;

  modport source (output valid, result_code, ident_out, status_out, not_in_use, input ready);
  modport sink   (input valid, result_code, ident_out, status_out, not_in_use, output ready);
endinterface

`default_nettype wire

[rtl/transaction_id_allocator.sv]
// A lookup command (release, set, get) passes the lookup and finish states before its result
// is registered. Assign and find scan the pool 32 identities per cycle, up to the last chunk.
// One command is worked on at a time; the chunk scan of the pool bitmaps sets the search
// time, and the finish state waits while the result register is still full.
// Reset (synchronous, rst_n low) frees every identity, clears the next-fit pointer and
// empties the result register; status bits are written by assign before they are read.
`default_nettype none

// Top level of the transaction identity allocator.
//
// The pool holds ID_COUNT identities numbered from 1. Each has an allocated bit and a
// status bit (inactive or pending), both kept in flip-flops so that a search can look
// at a whole 32-entry chunk of the pool per cycle.
//
// A command transfer is taken only while the controller is idle. Assign and find step a
// chunk pointer through the pool; a lowest-set-bit encoder picks the first candidate in
// the current chunk. Assign starts at the next-fit pointer, masks the entries below it on
// the first pass and comes back to the start chunk at the end for the entries it skipped,
// so the search wraps around exactly once. Find starts at identity 1.
//
// Release, set status and get status read the addressed entry into a register in the lookup
// state and decide in the finish state. All pool updates are made in the same cycle that loads
// the result register, so the next command always sees them.
//
// The result register decouples the two sides: a finished result can wait there for its
// transfer while the next command is accepted and worked on; that command only stalls
// at its final cycle if the register is still full.
module transaction_id_allocator import tia_pkg::*; #(
  parameter int ID_COUNT = 254
) (
  input  logic      clk,
  input  logic      rst_n,
  tia_in_if.sink    in_ch,
  tia_out_if.source out_ch
);

  tia_dp_cmd_t dp_cmd;
  tia_dp_sts_t dp_sts;
  logic        in_ready;

  tia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .dp_sts   (dp_sts),
    .dp_cmd   (dp_cmd)
  );

  tia_dp #(
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_ch.cmd),
    .in_ident        (in_ch.ident),
    .in_new_status   (in_ch.new_status),
    .dp_cmd          (dp_cmd),
    .dp_sts          (dp_sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_result_code (out_ch.result_code),
    .out_ident_out   (out_ch.ident_out),
    .out_status_out  (out_ch.status_out),
    .out_not_in_use  (out_ch.not_in_use)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

[rtl/tia_ctrl.sv]
// Controller state machine of the allocator.
`default_nettype none

module tia_ctrl import tia_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tia_dp_sts_t dp_sts,
  output tia_dp_cmd_t dp_cmd
);

  tia_state_t state_r;
  tia_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (dp_sts.in_search) begin
            state_nxt = ST_SEARCH;
          end else if (dp_sts.in_lookup) begin
            state_nxt = ST_LOOKUP;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SEARCH: begin
        if (dp_sts.hit || dp_sts.last_step) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (dp_sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    dp_cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        dp_cmd.load = in_valid;
      end
      ST_SEARCH: begin
        dp_cmd.step = 1'b1;
      end
      ST_LOOKUP: begin
        dp_cmd.lookup = 1'b1;
      end
      ST_FINISH: begin
        dp_cmd.commit = dp_sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/tia_dp.sv]
// Datapath of the allocator: bitmaps, chunked search, lookup and result register.
`default_nettype none
`include "assert_macros.svh"

module tia_dp import tia_pkg::*; #(
  parameter int ID_COUNT = 254
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ID_W-1:0]  in_ident,
  input  logic             in_new_status,
  input  tia_dp_cmd_t      dp_cmd,
  output tia_dp_sts_t      dp_sts,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_result_code,
  output logic [ID_W-1:0]  out_ident_out,
  output logic             out_status_out,
  output logic             out_not_in_use
);

  localparam int NCH    = (ID_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD_W  = (2 ** CH_W) * CHUNK_W;
  localparam int SLOT_W = CH_W + OFF_W;
  localparam int STEP_W = $clog2(NCH + 1);

  // Latched command.
  logic [CMD_W-1:0]  cmd_r;
  logic              st_r;
  logic              in_range_r;
  logic [SLOT_W-1:0] slot_r;

  // Pool state. Bits above ID_COUNT are never set.
  logic [PAD_W-1:0]  alloc_r;
  logic [PAD_W-1:0]  status_r;
  logic [ID_W-1:0]   ptr_r;

  // Search state.
  logic [CH_W-1:0]   chunk_r;
  logic [STEP_W-1:0] step_r;
  logic [OFF_W-1:0]  start_off_r;
  logic              found_r;
  logic [SLOT_W-1:0] found_slot_r;

  // Lookup results.
  logic              look_alloc_r;
  logic              look_status_r;

  // Result register.
  logic              out_valid_r;
  logic              out_rc_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_st_r;
  logic              out_niu_r;

  logic              in_range;
  logic [ID_W-1:0]   in_slot;
  logic [SLOT_W-1:0] start_slot;
  logic [PAD_W-1:0]  cand;
  logic [CHUNK_W-1:0] word;
  logic [CHUNK_W-1:0] mask;
  logic [CHUNK_W-1:0] hit_vec;
  logic [CHUNK_W-1:0] low_bit;
  logic [OFF_W-1:0]  hit_off;
  logic              first_step;
  logic              last_step;
  logic [ID_W-1:0]   found_id;
  logic              res_rc;
  logic [ID_W-1:0]   res_id;
  logic              res_st;
  logic              res_niu;
  logic              do_release;
  logic              do_set;
  logic              in_use;

  // Command decode of the offered item, plus search and result status.
  always_comb begin
    dp_sts.in_search = 1'b0;
    dp_sts.in_lookup = 1'b0;
    dp_sts.hit       = |hit_vec;
    dp_sts.last_step = last_step;
    dp_sts.out_free  = !out_valid_r || out_ready;
    unique case (in_cmd) inside
      CMD_ASSIGN, CMD_FIND: dp_sts.in_search = 1'b1;
      CMD_RELEASE, CMD_SET_STATUS, CMD_GET_STATUS: dp_sts.in_lookup = 1'b1;
      default: dp_sts.in_search = 1'b0;
    endcase
  end

  assign in_slot  = in_ident - ID_W'(FIRST_ID);
  assign in_range = (in_ident >= ID_W'(FIRST_ID)) && (in_slot < ID_W'(ID_COUNT));

  // Next-fit starts at the pointer; find and a worn-out pointer start at zero.
  assign start_slot = ((in_cmd == CMD_ASSIGN) && (ptr_r < ID_W'(ID_COUNT))) ?
                      ptr_r[SLOT_W-1:0] : '0;

  for (genvar g = 0; g < PAD_W; g++) begin : g_cand
    if (g < ID_COUNT) begin : g_live
      assign cand[g] = (cmd_r == CMD_ASSIGN) ? ~alloc_r[g] :
                       (alloc_r[g] & (status_r[g] == st_r));
    end else begin : g_pad
      assign cand[g] = 1'b0;
    end
  end

  assign first_step = (step_r == '0);
  assign last_step  = (step_r == STEP_W'(NCH));
  assign word       = cand[{chunk_r, OFF_W'(0)} +: CHUNK_W];

  // The start chunk is seen twice: first from the start offset up, at the end below it.
  always_comb begin
    if (first_step) begin
      mask = {CHUNK_W{1'b1}} << start_off_r;
    end else if (last_step) begin
      mask = ~({CHUNK_W{1'b1}} << start_off_r);
    end else begin
      mask = {CHUNK_W{1'b1}};
    end
  end

  assign hit_vec = word & mask;
  assign low_bit = hit_vec & (~hit_vec + CHUNK_W'(1));

  always_comb begin
    hit_off = '0;
    for (int b = 0; b < OFF_W; b++) begin
      for (int i = 0; i < CHUNK_W; i++) begin
        if (((i >> b) & 1) == 1) begin
          hit_off[b] = hit_off[b] | low_bit[i];
        end
      end
    end
  end

  // Command latch, search and lookup registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r       <= in_cmd;
      st_r        <= in_new_status;
      in_range_r  <= in_range;
      slot_r      <= in_slot[SLOT_W-1:0];
      chunk_r     <= start_slot[SLOT_W-1:OFF_W];
      start_off_r <= start_slot[OFF_W-1:0];
      step_r      <= '0;
      found_r     <= 1'b0;
    end else if (dp_cmd.step) begin
      if (dp_sts.hit) begin
        found_r      <= 1'b1;
        found_slot_r <= {chunk_r, hit_off};
      end else if (!last_step) begin
        chunk_r <= (chunk_r == CH_W'(NCH - 1)) ? '0 : chunk_r + CH_W'(1);
        step_r  <= step_r + STEP_W'(1);
      end
    end
    if (dp_cmd.lookup) begin
      look_alloc_r  <= alloc_r[slot_r];
      look_status_r <= status_r[slot_r];
    end
  end

  assign found_id   = ID_W'(found_slot_r) + ID_W'(FIRST_ID);
  assign in_use     = in_range_r && look_alloc_r;
  assign do_release = in_use && !look_status_r;
  assign do_set     = in_use && (look_status_r != st_r);

  always_comb begin
    res_rc  = RC_ERR;
    res_id  = '0;
    res_st  = 1'b0;
    res_niu = 1'b0;
    case (cmd_r) inside
      CMD_ASSIGN, CMD_FIND: begin
        res_rc = found_r ? RC_OK : RC_ERR;
        res_id = found_r ? found_id : '0;
      end
      CMD_RELEASE: begin
        res_rc = do_release ? RC_OK : RC_ERR;
      end
      CMD_SET_STATUS: begin
        res_rc = do_set ? RC_OK : RC_ERR;
      end
      CMD_GET_STATUS: begin
        res_rc  = RC_OK;
        res_st  = in_use && look_status_r;
        res_niu = !in_use;
      end
      default: begin
        res_rc = RC_ERR;
      end
    endcase
  end

  // Pool state updates land together with the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      ptr_r   <= '0;
    end else if (dp_cmd.commit) begin
      if ((cmd_r == CMD_ASSIGN) && found_r) begin
        alloc_r[found_slot_r] <= 1'b1;
        ptr_r                 <= ID_W'(found_slot_r) + ID_W'(1);
      end else if ((cmd_r == CMD_RELEASE) && do_release) begin
        alloc_r[slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      if ((cmd_r == CMD_ASSIGN) && found_r) begin
        status_r[found_slot_r] <= 1'b0;
      end else if ((cmd_r == CMD_SET_STATUS) && do_set) begin
        status_r[slot_r] <= st_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      out_rc_r  <= res_rc;
      out_id_r  <= res_id;
      out_st_r  <= res_st;
      out_niu_r <= res_niu;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_code = out_rc_r;
  assign out_ident_out   = out_id_r;
  assign out_status_out  = out_st_r;
  assign out_not_in_use  = out_niu_r;

  `TIA_ASSERT_IMP(a_found_in_pool, dp_cmd.commit && found_r, {1'b0, found_slot_r} < (SLOT_W + 1)'(ID_COUNT), "found slot lies outside the pool")
  `TIA_ASSERT_IMP(a_step_bound, dp_cmd.step, step_r <= STEP_W'(NCH), "search ran past its last chunk")
  `TIA_ASSERT_IMP(a_assign_free, dp_cmd.commit && (cmd_r == CMD_ASSIGN) && found_r, !alloc_r[found_slot_r], "assign picked an allocated identity")
  `TIA_ASSERT(a_ptr_bound, ptr_r <= ID_W'(ID_COUNT), "next-fit pointer beyond the pool")

endmodule

`default_nettype wire

[tb/tb_transaction_id_allocator.sv]
// Self-checking testbench for the transaction identity allocator.
module tb_transaction_id_allocator;
  import tia_pkg::*;

  // Pool size used for the device under test and for the predictor.
  localparam int POOL_SIZE = 254;

  // Cycles to wait after the last result so that a stray extra result shows up.
  localparam int DRAIN_CYCLES = 40;

  // One result transfer as the predictor expects it.
  typedef struct packed {
    logic            result_code;
    logic [ID_W-1:0] ident_out;
    logic            status_out;
    logic            not_in_use;
  } reply_t;

  logic clk;
  logic rst_n;

  tia_in_if  in_ch ();
  tia_out_if out_ch ();

  transaction_id_allocator #(
    .ID_COUNT(POOL_SIZE)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predictor state: allocated marks, status bits and the next-fit pointer.
  logic            pool_used    [POOL_SIZE];
  logic            pool_pending [POOL_SIZE];
  logic [ID_W-1:0] next_fit;

  // Replies still owed by the block, oldest first.
  reply_t pending_replies[$];

  int failures;

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct;
  int recv_stall_pct;

  always #1 clk = ~clk;

  // The result side drops ready at random; the stall rate follows the current phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predicts the reply to one command and updates the predictor's pool.
  function automatic reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                           input logic [ID_W-1:0]  ident,
                                           input logic             status);
    reply_t r;
    int     start;
    int     slot;
    int     k;
    bit     in_range;
    r        = '{result_code: RC_ERR, ident_out: '0, status_out: 1'b0, not_in_use: 1'b0};
    slot     = int'(ident) - FIRST_ID;
    in_range = (slot >= 0) && (slot < POOL_SIZE);
    case (cmd)
      CMD_ASSIGN: begin
        // Next-fit search from the pointer, wrapping once around the pool.
        start = (int'(next_fit) >= POOL_SIZE) ? 0 : int'(next_fit);
        for (k = 0; k < POOL_SIZE; k++) begin
          slot = (start + k) % POOL_SIZE;
          if (!pool_used[slot]) begin
            pool_used[slot]    = 1'b1;
            pool_pending[slot] = 1'b0;
            next_fit           = ID_W'(slot + 1);
            r.ident_out        = ID_W'(slot + FIRST_ID);
            r.result_code      = RC_OK;
            break;
          end
        end
      end
      CMD_RELEASE: begin
        if (in_range) begin
          if (pool_used[slot] && !pool_pending[slot]) begin
            pool_used[slot] = 1'b0;
            r.result_code   = RC_OK;
          end
        end
      end
      CMD_SET_STATUS: begin
        if (in_range) begin
          if (pool_used[slot] && pool_pending[slot] != status) begin
            pool_pending[slot] = status;
            r.result_code      = RC_OK;
          end
        end
      end
      CMD_GET_STATUS: begin
        r.result_code = RC_OK;
        r.not_in_use  = 1'b1;
        if (in_range) begin
          if (pool_used[slot]) begin
            r.status_out = pool_pending[slot];
            r.not_in_use = 1'b0;
          end
        end
      end
      CMD_FIND: begin
        for (k = 0; k < POOL_SIZE; k++) begin
          if (pool_used[k] && pool_pending[k] == status) begin
            r.ident_out   = ID_W'(k + FIRST_ID);
            r.result_code = RC_OK;
            break;
          end
        end
      end
      default: begin
        // Unused command codes leave the pool alone and report an error.
      end
    endcase
    return r;
  endfunction

  // Returns an allocated identity from a random starting point, or any identity if none.
  function automatic logic [ID_W-1:0] pick_live_ident();
    int base;
    int k;
    int slot;
    base = $urandom_range(POOL_SIZE - 1);
    for (k = 0; k < POOL_SIZE; k++) begin
      slot = (base + k) % POOL_SIZE;
      if (pool_used[slot]) return ID_W'(slot + FIRST_ID);
    end
    return ID_W'($urandom_range((1 << ID_W) - 1));
  endfunction

  // Sends one command and records its predicted reply once the transfer happens.
  // Valid is only lowered when a gap is taken, so it is never lowered and raised
  // in the same time step.
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic [ID_W-1:0]  ident,
                              input logic             status);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.cmd        <= cmd;
    in_ch.ident      <= ident;
    in_ch.new_status <= status;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_replies.push_back(apply_command(cmd, ident, status));
  endtask

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Every result transfer is matched against the oldest outstanding prediction.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with no command outstanding");
        failures++;
      end else begin
        want = pending_replies.pop_front();
        check_field("result_code", ID_W'(want.result_code), ID_W'(out_ch.result_code));
        check_field("ident_out", want.ident_out, out_ch.ident_out);
        check_field("status_out", ID_W'(want.status_out), ID_W'(out_ch.status_out));
        check_field("not_in_use", ID_W'(want.not_in_use), ID_W'(out_ch.not_in_use));
      end
    end
  end

  // Random commands drawn by weight. Most identities come from the allocated set
  // so that release and set status reach their success paths; the rest span the
  // whole 8-bit range, including zero and the identity above the pool.
  task automatic run_random(input int count, input int w_assign, input int w_release,
                            input int w_set, input int w_get, input int w_find,
                            input int w_bad);
    int               total;
    int               pick;
    int               slot;
    int               n;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  ident;
    logic             status;
    total = w_assign + w_release + w_set + w_get + w_find + w_bad;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(total - 1);
      if (pick < w_assign) cmd = CMD_ASSIGN;
      else if (pick < w_assign + w_release) cmd = CMD_RELEASE;
      else if (pick < w_assign + w_release + w_set) cmd = CMD_SET_STATUS;
      else if (pick < w_assign + w_release + w_set + w_get) cmd = CMD_GET_STATUS;
      else if (pick < total - w_bad) cmd = CMD_FIND;
      else cmd = CMD_W'($urandom_range(int'(CMD_FIND) + 1, (1 << CMD_W) - 1));
      if ($urandom_range(99) < 75) ident = pick_live_ident();
      else ident = ID_W'($urandom_range((1 << ID_W) - 1));
      slot = int'(ident) - FIRST_ID;
      // Set status mostly asks for a real change on a live identity.
      if (cmd == CMD_SET_STATUS && slot >= 0 && slot < POOL_SIZE && pool_used[slot] &&
          $urandom_range(99) < 70) begin
        status = !pool_pending[slot];
      end else begin
        status = 1'($urandom_range(1));
      end
      send_command(cmd, ident, status);
    end
  endtask

  // Short directed sequence over every command, the range limits and the error paths.
  task automatic test_directed();
    send_idle_pct  = 13;
    recv_stall_pct = 76;
    send_command(CMD_FIND, 8'd0, 1'b0);          // Nothing allocated: no match.
    send_command(CMD_GET_STATUS, 8'd0, 1'b0);    // Identity zero is out of range.
    send_command(CMD_GET_STATUS, 8'd255, 1'b1);  // Above the last identity.
    send_command(CMD_GET_STATUS, 8'd1, 1'b0);    // Free identity.
    send_command(CMD_RELEASE, 8'd0, 1'b0);
    send_command(CMD_RELEASE, 8'd255, 1'b1);
    send_command(CMD_RELEASE, 8'd1, 1'b0);       // Release of a free identity.
    send_command(CMD_SET_STATUS, 8'd1, 1'b1);    // Set status on a free identity.
    send_command(CMD_ASSIGN, 8'd0, 1'b0);
    send_command(CMD_ASSIGN, 8'd255, 1'b1);
    send_command(CMD_ASSIGN, 8'd0, 1'b0);
    send_command(CMD_SET_STATUS, 8'd2, 1'b0);    // Status unchanged.
    send_command(CMD_SET_STATUS, 8'd2, 1'b1);
    send_command(CMD_GET_STATUS, 8'd2, 1'b0);
    send_command(CMD_RELEASE, 8'd2, 1'b0);       // Release of a pending identity.
    send_command(CMD_FIND, 8'd0, 1'b1);
    send_command(CMD_FIND, 8'd255, 1'b0);
    send_command(CMD_SET_STATUS, 8'd254, 1'b1);  // Last identity, still free.
    send_command(CMD_GET_STATUS, 8'd254, 1'b1);
    send_command(CMD_FIND + 3'd1, 8'd255, 1'b1); // Unused command codes.
    send_command(CMD_FIND + 3'd2, 8'd0, 1'b0);
    send_command({CMD_W{1'b1}}, 8'd170, 1'b1);
    send_command(CMD_RELEASE, 8'd1, 1'b0);
    send_command(CMD_ASSIGN, 8'd0, 1'b0);        // Next fit skips the freed identity.
  endtask

  // Assign-heavy traffic fills the pool, so the pointer runs off the end and
  // wraps, and assigns then meet a full pool while releases open single holes.
  task automatic test_fill_and_wrap();
    send_idle_pct  = 13;
    recv_stall_pct = 76;
    run_random(420, 70, 8, 8, 6, 4, 4);
  endtask

  // Release-heavy traffic drains the pool and keeps holes moving behind the pointer.
  task automatic test_churn();
    send_idle_pct  = 76;
    recv_stall_pct = 13;
    run_random(380, 25, 35, 20, 10, 6, 4);
  endtask

  // Balanced traffic at full rate on both sides.
  task automatic test_back_to_back();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(320, 30, 25, 20, 12, 9, 4);
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_ASSIGN;
    in_ch.ident      = '0;
    in_ch.new_status = 1'b0;
    out_ch.ready     = 1'b0;
    failures         = 0;
    send_idle_pct    = 13;
    recv_stall_pct   = 76;
    next_fit         = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_used[i]    = 1'b0;
      pool_pending[i] = 1'b0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_wrap();
    test_churn();
    test_back_to_back();

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Let every outstanding reply arrive, then watch a while longer for extras.
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tia_pkg.sv
rtl/tia_in_if.sv
rtl/tia_out_if.sv
rtl/tia_ctrl.sv
rtl/tia_dp.sv
rtl/transaction_id_allocator.sv
tb/tb_transaction_id_allocator.sv
